>>> hdl/sus_pkg.sv
`timescale 1ns / 1ps

package sus_pkg;

    // Set capacity and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int CMD_W    = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;

    // Command codes carried by an item
    typedef enum logic [CMD_W-1:0] {
        OP_CLEAR    = 3'd0,
        OP_ADD      = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_TOGGLE   = 3'd3,
        OP_CONTAINS = 3'd4,
        OP_READ     = 3'd5
    } sus_op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // latch item, open the search window
        logic srch_rd;    // read the midpoint entry
        logic srch_cmp;   // narrow the window on the midpoint entry
        logic ins_init;   // start an upward shift from the top entry
        logic del_init;   // start a downward shift from the slot
        logic shift_ins;  // move one entry up
        logic shift_del;  // move one entry down
        logic put;        // write the value at the slot, count up
        logic dec;        // count down
        logic clear;      // empty the set
        logic pos_rd;     // read the entry at the requested position
        logic set_flag;   // raise the result flag
        logic out_load;   // load the output register
    } sus_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             found;
        logic             full;
        logic             search_done;
        logic             ins_busy;
        logic             del_busy;
        logic             out_free;
    } sus_sts_t;

endpackage

>>> hdl/sus_ctrl.sv
`timescale 1ns / 1ps

module sus_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sus_pkg::sus_sts_t sts,
    output sus_pkg::sus_ctl_t ctl
);
    import sus_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b000_0001,
        ST_SRCH_RD   = 7'b000_0010,
        ST_SRCH_CMP  = 7'b000_0100,
        ST_DECIDE    = 7'b000_1000,
        ST_SHIFT_INS = 7'b001_0000,
        ST_SHIFT_DEL = 7'b010_0000,
        ST_FINISH    = 7'b100_0000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence search, shift and result load
    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                if (sts.search_done) begin
                    state_next = ST_DECIDE;
                end else begin
                    ctl.srch_rd = 1'b1;
                    state_next  = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                ctl.srch_cmp = 1'b1;
                state_next   = ST_SRCH_RD;
            end
            ST_DECIDE: begin
                state_next = ST_FINISH;
                case (sts.cmd)
                    OP_CLEAR: begin
                        ctl.clear = 1'b1;
                    end
                    OP_ADD: begin
                        if (!sts.found && !sts.full) begin
                            ctl.ins_init = 1'b1;
                            ctl.set_flag = 1'b1;
                            state_next   = ST_SHIFT_INS;
                        end
                    end
                    OP_REMOVE: begin
                        if (sts.found) begin
                            ctl.del_init = 1'b1;
                            ctl.set_flag = 1'b1;
                            state_next   = ST_SHIFT_DEL;
                        end
                    end
                    OP_TOGGLE: begin
                        if (sts.found) begin
                            ctl.del_init = 1'b1;
                            state_next   = ST_SHIFT_DEL;
                        end else if (!sts.full) begin
                            ctl.ins_init = 1'b1;
                            ctl.set_flag = 1'b1;
                            state_next   = ST_SHIFT_INS;
                        end
                    end
                    OP_CONTAINS: begin
                        ctl.set_flag = sts.found;
                    end
                    OP_READ: begin
                        ctl.pos_rd = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SHIFT_INS: begin
                ctl.shift_ins = 1'b1;
                if (!sts.ins_busy) begin
                    ctl.put    = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT_DEL: begin
                ctl.shift_del = 1'b1;
                if (!sts.del_busy) begin
                    ctl.dec    = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/sus_dp.sv
`timescale 1ns / 1ps

module sus_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [sus_pkg::CMD_W-1:0]   s_cmd,
    input  logic [sus_pkg::VAL_W-1:0]   s_codepoint,
    input  logic [sus_pkg::POS_W-1:0]   s_position,
    input  sus_pkg::sus_ctl_t           ctl,
    output sus_pkg::sus_sts_t           sts,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_flag,
    output logic [sus_pkg::VAL_W-1:0]   m_read_value,
    output logic [sus_pkg::CNT_W-1:0]   m_entry_count
);
    import sus_pkg::*;

    // Entry store, no reset
    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] rdata_reg;

    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [VAL_W-1:0] cp_reg, cp_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] wr_addr_reg, wr_addr_next;
    logic             pend_reg, pend_next;
    logic             found_reg, found_next;
    logic             flag_reg, flag_next;

    logic             m_valid_reg, m_valid_next;
    logic             m_flag_reg, m_flag_next;
    logic [VAL_W-1:0] m_value_reg, m_value_next;
    logic [CNT_W-1:0] m_count_reg, m_count_next;

    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] ptr_dec;
    logic [CNT_W-1:0] ptr_inc;
    logic             ins_more;
    logic             del_more;

    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;

    // Midpoint and shift pointers
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CNT_W:1];
    assign ptr_dec  = ptr_reg - CNT_W'(1);
    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign ins_more = ptr_reg > lo_reg;
    assign del_more = ptr_inc < count_reg;

    // Steer the memory ports
    always_comb begin
        re    = 1'b0;
        raddr = mid[IDX_W-1:0];
        we    = 1'b0;
        waddr = wr_addr_reg;
        wdata = rdata_reg;
        if (ctl.srch_rd) begin
            re    = 1'b1;
            raddr = mid[IDX_W-1:0];
        end else if (ctl.pos_rd) begin
            re    = 1'b1;
            raddr = pos_reg[IDX_W-1:0];
        end else if (ctl.shift_ins && ins_more) begin
            re    = 1'b1;
            raddr = ptr_dec[IDX_W-1:0];
        end else if (ctl.shift_del && del_more) begin
            re    = 1'b1;
            raddr = ptr_inc[IDX_W-1:0];
        end
        if ((ctl.shift_ins || ctl.shift_del) && pend_reg) begin
            we    = 1'b1;
            waddr = wr_addr_reg;
            wdata = rdata_reg;
        end else if (ctl.put) begin
            we    = 1'b1;
            waddr = lo_reg[IDX_W-1:0];
            wdata = cp_reg;
        end
    end

    // Write and read the store
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    // Next state of the search, shift and count
    always_comb begin
        cmd_next     = cmd_reg;
        cp_next      = cp_reg;
        pos_next     = pos_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        ptr_next     = ptr_reg;
        count_next   = count_reg;
        wr_addr_next = wr_addr_reg;
        pend_next    = pend_reg;
        found_next   = found_reg;
        flag_next    = flag_reg;

        if (ctl.load) begin
            cmd_next   = s_cmd;
            cp_next    = s_codepoint;
            pos_next   = s_position;
            lo_next    = '0;
            hi_next    = count_reg;
            found_next = 1'b0;
            flag_next  = 1'b0;
        end
        if (ctl.srch_rd) begin
            mid_next = mid;
        end
        if (ctl.srch_cmp) begin
            if (rdata_reg < cp_reg) begin
                lo_next = mid_reg + CNT_W'(1);
            end else begin
                hi_next = mid_reg;
            end
            if (rdata_reg == cp_reg) begin
                found_next = 1'b1;
            end
        end
        if (ctl.set_flag) begin
            flag_next = 1'b1;
        end
        if (ctl.ins_init) begin
            ptr_next  = count_reg;
            pend_next = 1'b0;
        end
        if (ctl.del_init) begin
            ptr_next  = lo_reg;
            pend_next = 1'b0;
        end
        // Move one entry up: read below, write the slot above next cycle
        if (ctl.shift_ins) begin
            pend_next = ins_more;
            if (ins_more) begin
                ptr_next     = ptr_dec;
                wr_addr_next = ptr_reg[IDX_W-1:0];
            end
        end
        // Move one entry down: read above, write this slot next cycle
        if (ctl.shift_del) begin
            pend_next = del_more;
            if (del_more) begin
                ptr_next     = ptr_inc;
                wr_addr_next = ptr_reg[IDX_W-1:0];
            end
        end
        if (ctl.put) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (ctl.dec) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (ctl.clear) begin
            count_next = '0;
        end
    end

    // Output register: load a finished item, drop it when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_flag_next  = m_flag_reg;
        m_value_next = m_value_reg;
        m_count_next = m_count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctl.out_load) begin
            m_valid_next = 1'b1;
            m_flag_next  = flag_reg;
            m_count_next = count_reg;
            if ((cmd_reg == OP_READ) && (pos_reg < count_reg)) begin
                m_value_next = rdata_reg;
            end else begin
                m_value_next = '0;
            end
        end
    end

    // Hold payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        cp_reg      <= cp_next;
        pos_reg     <= pos_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        found_reg   <= found_next;
        flag_reg    <= flag_next;
        m_flag_reg  <= m_flag_next;
        m_value_reg <= m_value_next;
        m_count_reg <= m_count_next;
    end

    // Hold control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Report status
    always_comb begin
        sts.cmd         = cmd_reg;
        sts.found       = found_reg;
        sts.full        = count_reg == CNT_W'(CAPACITY);
        sts.search_done = lo_reg == hi_reg;
        sts.ins_busy    = ins_more || pend_reg;
        sts.del_busy    = del_more || pend_reg;
        sts.out_free    = !m_valid_reg || m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_flag        = m_flag_reg;
    assign m_read_value  = m_value_reg;
    assign m_entry_count = m_count_reg;

endmodule

>>> hdl/sorted_unique_set.sv
// Each item runs a binary search over the stored entries, reading the midpoint and then
// narrowing the window on it; an insert then shifts the entries from the top down to the
// slot up by one and writes the value there, and a delete shifts the entries above the slot
// down by one. One item is in work at a time: the next is accepted in the cycle after the
// result is loaded, and a result waiting on m_ready holds the controller.
// Reset: empties the set and output; entries are not cleared.
`timescale 1ns / 1ps

module sorted_unique_set (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sus_pkg::CMD_W-1:0]   s_cmd,
    input  logic [sus_pkg::VAL_W-1:0]   s_codepoint,
    input  logic [sus_pkg::POS_W-1:0]   s_position,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_flag,
    output logic [sus_pkg::VAL_W-1:0]   m_read_value,
    output logic [sus_pkg::CNT_W-1:0]   m_entry_count
);
    import sus_pkg::*;

    sus_ctl_t ctl;
    sus_sts_t sts;

    sus_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    sus_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_cmd         (s_cmd),
        .s_codepoint   (s_codepoint),
        .s_position    (s_position),
        .ctl           (ctl),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_flag        (m_flag),
        .m_read_value  (m_read_value),
        .m_entry_count (m_entry_count)
    );

    // One item in flight: no second accept straight after the first
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while another is in work");

    // Never overfill the set
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.put |-> !sts.full)
        else $error("insert into a full set");

    // Never overwrite a result that is still waiting
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> sts.out_free)
        else $error("result loaded over a waiting item");

    // Reported count stays within capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entry_count <= CNT_W'(CAPACITY)))
        else $error("entry count beyond capacity");

endmodule
